// ----- src/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the console line editor: key codes,
// result kinds, queue commands and back-end states.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int LINE_DEPTH_DEF = 40;
    localparam int CMD_DEPTH_DEF  = 2;
    localparam int RES_DEPTH_DEF  = 4;

    localparam logic [7:0] KEY_BS       = 8'h08;
    localparam logic [7:0] KEY_ESC      = 8'h1B;
    localparam logic [7:0] KEY_LBRACKET = 8'h5B;
    localparam logic [7:0] KEY_UP       = 8'h41;
    localparam logic [7:0] KEY_CR       = 8'h0D;

    typedef enum logic [1:0] {
        KIND_LINE   = 2'd0,
        KIND_END    = 2'd1,
        KIND_CURSOR = 2'd2,
        KIND_ECHO   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_RECALL = 2'd1,
        OP_SUBMIT = 2'd2
    } cmd_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_RUN,
        ST_TAIL
    } back_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } res_t;

endpackage

// ----- src/cle_fifo.sv -----
// ----------------------------------------------------------------------------
// cle_fifo
// Small register queue with push/full and pop/empty sides and a fill level.
// ----------------------------------------------------------------------------
module cle_fifo
    import cle_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [LW-1:0]    level_reg;
    logic [LW-1:0]    level_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign dout    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- src/cle_front.sv -----
// ----------------------------------------------------------------------------
// cle_front
// Takes received bytes, tracks line fill, escape mark and history length,
// and turns each byte, but a backspace that deletes, into a store, recall or submit command.
// ----------------------------------------------------------------------------
module cle_front
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [7:0]                    rx_byte,
    input  logic                          cmd_full,
    output logic                          cmd_push,
    output cmd_op_t                       cmd_op,
    output logic [$clog2(LINE_DEPTH)-1:0] cmd_arg,
    output logic [7:0]                    cmd_data
);

    localparam int CW = $clog2(LINE_DEPTH+1);
    localparam int AW = $clog2(LINE_DEPTH);

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [CW-1:0] esc_reg;
    logic [CW-1:0] esc_next;
    logic [CW-1:0] zero_pos_reg;
    logic [CW-1:0] zero_pos_next;
    logic [AW-1:0] hist_len_reg;
    logic [AW-1:0] hist_len_next;
    logic [7:0]    mark0_reg;
    logic [7:0]    mark0_next;
    logic [7:0]    mark1_reg;
    logic [7:0]    mark1_next;
    logic [7:0]    mark2_reg;
    logic [7:0]    mark2_next;

    logic          accept;
    logic          line_full;
    logic [CW-1:0] fill0;
    logic [CW-1:0] zero_pos0;
    logic          bs_del;
    logic [CW-1:0] wpos;
    logic [7:0]    wdata;
    logic [CW-1:0] fill_w;
    logic [CW-1:0] esc_w;
    logic [CW-1:0] zero_pos_w;
    logic [7:0]    m0;
    logic [7:0]    m1;
    logic [7:0]    m2;
    logic          up_match;

    assign accept = push && !cmd_full;

    always_comb
    begin
        line_full = (fill_reg == CW'(LINE_DEPTH));
        fill0     = line_full ? '0 : fill_reg;
        zero_pos0 = line_full ? '0 : zero_pos_reg;
        m0        = line_full ? '0 : mark0_reg;
        m1        = line_full ? '0 : mark1_reg;
        m2        = line_full ? '0 : mark2_reg;
        bs_del    = (rx_byte == KEY_BS) && (fill0 != '0);
        wpos      = bs_del ? fill0 - CW'(1) : fill0;
        wdata     = bs_del ? 8'h00 : rx_byte;
        esc_w     = esc_reg;

        // keep copies of the three bytes at the escape mark
        if (({1'b0, wpos} + (CW+1)'(1)) == {1'b0, esc_reg})
        begin
            m0 = wdata;
        end
        if (wpos == esc_reg)
        begin
            m1 = wdata;
        end
        if ({1'b0, wpos} == ({1'b0, esc_reg} + (CW+1)'(1)))
        begin
            m2 = wdata;
        end

        if (bs_del)
        begin
            fill_w     = wpos;
            zero_pos_w = (zero_pos0 > wpos) ? wpos : zero_pos0;
        end
        else
        begin
            fill_w     = fill0 + CW'(1);
            zero_pos_w = ((zero_pos0 == fill0) && (rx_byte != 8'h00)) ? fill_w : zero_pos0;
            if (rx_byte == KEY_ESC)
            begin
                esc_w = fill_w;
                m0    = KEY_ESC;
                m1    = 8'h00;
                m2    = 8'h00;
            end
        end

        up_match = !bs_del && (esc_w != '0)
                   && (({1'b0, esc_w} + (CW+1)'(2)) <= (CW+1)'(LINE_DEPTH))
                   && (m0 == KEY_ESC) && (m1 == KEY_LBRACKET) && (m2 == KEY_UP);

        fill_next     = fill_reg;
        esc_next      = esc_reg;
        zero_pos_next = zero_pos_reg;
        hist_len_next = hist_len_reg;
        mark0_next    = mark0_reg;
        mark1_next    = mark1_reg;
        mark2_next    = mark2_reg;
        cmd_push      = 1'b0;
        cmd_op        = OP_WRITE;
        cmd_arg       = fill0[AW-1:0];
        cmd_data      = rx_byte;

        if (accept)
        begin
            priority if (bs_del)
            begin
                fill_next     = fill_w;
                zero_pos_next = zero_pos_w;
                mark0_next    = m0;
                mark1_next    = m1;
                mark2_next    = m2;
            end
            else if (up_match)
            begin
                cmd_push      = 1'b1;
                cmd_op        = OP_RECALL;
                cmd_arg       = hist_len_reg;
                fill_next     = CW'(hist_len_reg);
                zero_pos_next = CW'(hist_len_reg);
                esc_next      = '0;
                mark0_next    = '0;
                mark1_next    = '0;
                mark2_next    = '0;
            end
            else if (rx_byte == KEY_CR)
            begin
                cmd_push      = 1'b1;
                cmd_op        = OP_SUBMIT;
                cmd_arg       = zero_pos0[AW-1:0];
                hist_len_next = zero_pos0[AW-1:0];
                fill_next     = '0;
                zero_pos_next = '0;
                esc_next      = '0;
                mark0_next    = '0;
                mark1_next    = '0;
                mark2_next    = '0;
            end
            else
            begin
                cmd_push      = 1'b1;
                cmd_op        = OP_WRITE;
                fill_next     = fill_w;
                zero_pos_next = zero_pos_w;
                esc_next      = esc_w;
                mark0_next    = m0;
                mark1_next    = m1;
                mark2_next    = m2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            esc_reg      <= '0;
            zero_pos_reg <= '0;
            hist_len_reg <= '0;
            mark0_reg    <= '0;
            mark1_reg    <= '0;
            mark2_reg    <= '0;
        end
        else
        begin
            fill_reg     <= fill_next;
            esc_reg      <= esc_next;
            zero_pos_reg <= zero_pos_next;
            hist_len_reg <= hist_len_next;
            mark0_reg    <= mark0_next;
            mark1_reg    <= mark1_next;
            mark2_reg    <= mark2_next;
        end
    end

endmodule

// ----- src/cle_back.sv -----
// ----------------------------------------------------------------------------
// cle_back
// Carries out queued commands against the line and history memories and
// streams the resulting records into the result queue.
// ----------------------------------------------------------------------------
module cle_back
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF,
    parameter int RES_DEPTH  = RES_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_empty,
    input  cmd_op_t                        cmd_op,
    input  logic [$clog2(LINE_DEPTH)-1:0]  cmd_arg,
    input  logic [7:0]                     cmd_data,
    output logic                           cmd_pop,
    input  logic                           res_full,
    input  logic [$clog2(RES_DEPTH+1)-1:0] res_level,
    output logic                           res_push,
    output res_t                           res_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LW = $clog2(RES_DEPTH+1);

    logic [7:0] line_mem [LINE_DEPTH];
    logic [7:0] hist_mem [LINE_DEPTH];

    back_state_t   state_reg;
    back_state_t   state_next;
    cmd_op_t       op_reg;
    cmd_op_t       op_next;
    logic [AW-1:0] len_reg;
    logic [AW-1:0] len_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic          rd_valid_reg;
    logic          rd_valid_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_idx_next;
    logic [7:0]    line_rd_reg;
    logic [7:0]    hist_rd_reg;

    logic          rd_en;
    logic [7:0]    rd_byte;
    logic          line_we;
    logic [AW-1:0] line_waddr;
    logic [7:0]    line_wdata;
    logic          hist_we;

    assign rd_byte = (op_reg == OP_RECALL) ? hist_rd_reg : line_rd_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        res_data      = '0;
        line_we       = 1'b0;
        line_waddr    = rd_idx_reg;
        line_wdata    = rd_byte;
        hist_we       = 1'b0;
        rd_en         = 1'b0;

        // read data stage: copy one byte across and report it
        if (rd_valid_reg)
        begin
            res_push      = 1'b1;
            res_data.data = rd_byte;
            if (op_reg == OP_RECALL)
            begin
                res_data.kind = KIND_ECHO;
                res_data.last = (({1'b0, rd_idx_reg} + (AW+1)'(1)) == {1'b0, len_reg});
                line_we       = 1'b1;
            end
            else
            begin
                res_data.kind = KIND_LINE;
                res_data.last = 1'b0;
                hist_we       = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && !rd_valid_reg)
                begin
                    cmd_pop  = 1'b1;
                    op_next  = cmd_op;
                    len_next = cmd_arg;
                    idx_next = '0;
                    unique case (cmd_op)
                        OP_WRITE:
                        begin
                            line_we    = 1'b1;
                            line_waddr = cmd_arg;
                            line_wdata = cmd_data;
                        end
                        OP_RECALL:
                        begin
                            state_next = ST_HEAD;
                        end
                        OP_SUBMIT:
                        begin
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_HEAD:
            begin
                if (!res_full)
                begin
                    res_push      = 1'b1;
                    res_data.kind = KIND_CURSOR;
                    res_data.data = 8'h00;
                    res_data.last = (len_reg == '0);
                    state_next    = (len_reg == '0) ? ST_IDLE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (idx_reg != len_reg)
                begin
                    // one slot in the result queue is held for the read in flight
                    if (({1'b0, res_level} + (LW+1)'(rd_valid_reg)) < (LW+1)'(RES_DEPTH))
                    begin
                        rd_en         = 1'b1;
                        rd_valid_next = 1'b1;
                        rd_idx_next   = idx_reg;
                        idx_next      = idx_reg + AW'(1);
                    end
                end
                else if (!rd_valid_reg)
                begin
                    state_next = (op_reg == OP_SUBMIT) ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (!res_full)
                begin
                    res_push      = 1'b1;
                    res_data.kind = KIND_END;
                    res_data.data = 8'h00;
                    res_data.last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_WRITE;
            len_reg      <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
            rd_idx_reg   <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        if (hist_we)
        begin
            hist_mem[rd_idx_reg] <= rd_byte;
        end
        if (rd_en)
        begin
            line_rd_reg <= line_mem[idx_reg];
            hist_rd_reg <= hist_mem[idx_reg];
        end
    end

endmodule

// ----- src/console_line_editor_core.sv -----
// ----------------------------------------------------------------------------
// console_line_editor_core
// Line editor for bytes received from a serial console, with one-line
// history recall on ESC [ A and line submission on CR.
// ----------------------------------------------------------------------------
// Input channel: drive rx_byte and raise push; the byte is taken on a clock
// edge where full is low. Output channel: while empty is low, out_kind,
// out_byte and out_last show the oldest result; pop takes it. out_last marks
// the final result caused by one input byte.
// Ordinary bytes, backspace and escape bytes give no result and are taken
// one per cycle while full is low. A submit gives n line bytes plus a line
// end; a recall gives a cursor-down request plus n echo bytes (n up to
// LINE_DEPTH-1). Once the command reaches the back end, the results of such
// a transaction follow at one result per cycle while the result queue has
// room, and the transaction holds the back end until its last result; the
// single read port of each line memory sets that pace.
// A two-entry command queue sits between front and back, so up to two more
// commands (backspaces that delete make none) are queued while a long
// transaction is still streaming; after that full stays high. When pop stays
// low the four-entry result queue fills and the back end waits with no result lost.
// After reset the line and history are empty; the memories need no clearing
// pass since only positions below the tracked lengths are ever read.
// ----------------------------------------------------------------------------
module console_line_editor_core
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int CMD_W = 2 + AW + 8;
    localparam int RES_W = $bits(res_t);
    localparam int RLW   = $clog2(RES_DEPTH_DEF+1);
    localparam int CLW   = $clog2(CMD_DEPTH_DEF+1);

    logic             cmd_push;
    cmd_op_t          cmd_op_in;
    logic [AW-1:0]    cmd_arg_in;
    logic [7:0]       cmd_data_in;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_head;
    logic [CLW-1:0]   cmd_level;

    logic             res_push;
    res_t             res_in;
    logic             res_full;
    logic [RLW-1:0]   res_level;
    res_t             res_head;

    assign full = cmd_full;

    cle_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_op   (cmd_op_in),
        .cmd_arg  (cmd_arg_in),
        .cmd_data (cmd_data_in)
    );

    cle_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH_DEF)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   ({cmd_op_in, cmd_arg_in, cmd_data_in}),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (cmd_empty),
        .level (cmd_level)
    );

    cle_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .RES_DEPTH  (RES_DEPTH_DEF)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_op    (cmd_op_t'(cmd_head[CMD_W-1 -: 2])),
        .cmd_arg   (cmd_head[8 +: AW]),
        .cmd_data  (cmd_head[7:0]),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_level (res_level),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    cle_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH_DEF)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty),
        .level (res_level)
    );

    assign out_kind = res_head.kind;
    assign out_byte = res_head.data;
    assign out_last = res_head.last;

    // the back end never pushes into a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) !(res_push && res_full))
        else $error("result queue overrun");

    // the command queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_level <= CLW'(CMD_DEPTH_DEF))
        else $error("command queue level out of range");

    // line end and cursor-down carry no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_kind == KIND_END || out_kind == KIND_CURSOR)) |-> (out_byte == 8'h00))
        else $error("control result with nonzero byte");

    // a line end always closes its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == KIND_END) |-> out_last)
        else $error("line end without last flag");

endmodule
